[hdl/four_level_page_table_manager_top_assert.svh]
// Assertion macros for the page table engine.
`ifndef FOUR_LEVEL_PAGE_TABLE_MANAGER_TOP_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_MANAGER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PT_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define PT_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[hdl/fpt_pkg.sv]
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared constants and types of the page table engine.
// ----------------------------------------------------------------------------
package fpt_pkg;
  localparam int NUM_FRAMES_DEF = 64;
  localparam int POOL_SLOTS_DEF = 64;
  localparam int ENTRIES_PER_TABLE = 512;

  typedef enum logic [2:0] {
    K_TRANSLATE = 3'd0, K_MAP = 3'd1, K_UNMAP = 3'd2,
    K_ALLOC = 3'd3, K_FREE = 3'd4, K_SEED = 3'd5, K_NOP6 = 3'd6, K_NOP7 = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_NO_ROOT = 4'd1, ST_L1_ABSENT = 4'd2, ST_L2_ABSENT = 4'd3,
    ST_L3_ABSENT = 4'd4, ST_L4_ABSENT = 4'd5, ST_ALREADY = 4'd6,
    ST_EMPTY = 4'd7, ST_BAD = 4'd8, ST_FULL = 4'd9
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_POOL_RD, S_POOL_WAIT, S_TBL_RD, S_TBL_WAIT,
    S_TBL_EVAL, S_FRAME_RD, S_FRAME_WAIT, S_OUT
  } state_t;

  // Nine-bit table index of a level (0 = root) taken from a virtual address.
  function automatic logic [8:0] level_index(input logic [47:0] va, input logic [1:0] lvl);
    logic [8:0] idx;
    unique case (lvl)
      2'd0: idx = va[47:39];
      2'd1: idx = va[38:30];
      2'd2: idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction
endpackage

[hdl/four_level_page_table_manager_top.sv]
// From acceptance to result valid: free, seed, undefined kinds and rejected roots go
// straight to output; allocate reads the pool first; a translate or unmap walk reads
// four levels, and a map may add three table builds (three pool pops, one table port).
// Throughput: one item at a time; ready only in idle, output held in a register.
// Reset: control clears at once, then a clearing pass zeroes the table memory; no item
// is accepted during the pass.
// ----------------------------------------------------------------------------
// four_level_page_table_manager_top
// Sequenced four-level page table walker with a free-frame pool.
// ----------------------------------------------------------------------------
module four_level_page_table_manager_top
  import fpt_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [5:0]  in_root_frame,
  input  logic [47:0] in_virtual_address,
  input  logic [51:0] in_physical_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic [62:0] out_result_address
);
  `include "four_level_page_table_manager_top_assert.svh"

  localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int AW = FW + 9;
  localparam int DEPTH = NUM_FRAMES * ENTRIES_PER_TABLE;
  localparam int PW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CW = $clog2(POOL_SLOTS + 1);

  // Table memory and free-frame stack, each with a registered read.
  logic [63:0] tbl_mem [DEPTH];
  logic [FW-1:0] pool_mem [POOL_SLOTS];

  state_t st_r, st_nxt;
  logic [2:0]  kind_r;
  logic [47:0] va_r;
  logic [51:0] pa_r;
  logic [FW-1:0] cur_r;
  logic [1:0]  lvl_r;
  logic [CW-1:0] alloc_r, fill_r;
  logic [AW-1:0] clr_r;
  logic [63:0] tbl_q_r;
  logic [FW-1:0] pool_q_r;
  logic [3:0]  status_r;
  logic [62:0] res_r;

  // Sequencer-driven memory controls.
  logic tbl_we, pool_we;
  logic [AW-1:0] tbl_addr;
  logic [63:0] tbl_wd;
  logic [PW-1:0] pool_waddr, pool_raddr;
  logic [FW-1:0] pool_wd;

  // Decode helpers.
  logic pa_ok, pool_avail, root_ok, ptr_ok;
  logic [39:0] ptr_frame;
  logic [AW-1:0] walk_addr;
  status_t acc_status;

  assign pa_ok = (pa_r[11:0] == 12'd0) && ({12'd0, pa_r[51:12]} < 52'(NUM_FRAMES));
  assign pool_avail = (alloc_r < fill_r) && (alloc_r < CW'(POOL_SLOTS));
  assign root_ok = 32'(in_root_frame) < 32'(NUM_FRAMES);
  assign ptr_frame = tbl_q_r[51:12];
  assign ptr_ok = {24'd0, ptr_frame} < 64'(NUM_FRAMES);
  assign walk_addr = {cur_r, level_index(va_r, lvl_r)};

  // Status known at acceptance: root checks for walks, address and pool
  // bounds for free and seed.
  always_comb begin
    acc_status = ST_OK;
    if (in_kind == K_TRANSLATE || in_kind == K_MAP || in_kind == K_UNMAP) begin
      if (in_root_frame == 6'd0) acc_status = ST_NO_ROOT;
      else if (!root_ok) acc_status = ST_BAD;
    end else if (in_kind == K_FREE || in_kind == K_SEED) begin
      if (in_physical_address[11:0] != 12'd0 ||
          {12'd0, in_physical_address[51:12]} >= 52'(NUM_FRAMES))
        acc_status = ST_BAD;
      else if (in_kind == K_FREE &&
               (alloc_r == '0 || alloc_r > CW'(POOL_SLOTS)))
        acc_status = ST_FULL;
      else if (in_kind == K_SEED && fill_r >= CW'(POOL_SLOTS))
        acc_status = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_addr] <= tbl_wd;
    tbl_q_r <= tbl_mem[tbl_addr];
  end

  always_ff @(posedge clk) begin
    if (pool_we) pool_mem[pool_waddr] <= pool_wd;
    pool_q_r <= pool_mem[pool_raddr];
  end

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_status = status_r;
  assign out_result_address = res_r;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_CLEAR: if (clr_r == AW'(DEPTH - 1)) st_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          priority if (in_kind == K_TRANSLATE || in_kind == K_MAP || in_kind == K_UNMAP)
            st_nxt = (in_root_frame != 6'd0 && root_ok) ? S_TBL_RD : S_OUT;
          else if (in_kind == K_ALLOC) st_nxt = S_POOL_RD;
          else st_nxt = S_OUT;
        end
      end
      S_POOL_RD:   st_nxt = pool_avail ? S_POOL_WAIT : S_OUT;
      S_POOL_WAIT: st_nxt = S_OUT;
      S_TBL_RD:    st_nxt = S_TBL_WAIT;
      S_TBL_WAIT:  st_nxt = S_TBL_EVAL;
      S_TBL_EVAL: begin
        priority if (lvl_r == 2'd3) st_nxt = S_OUT;
        else if (tbl_q_r[0]) st_nxt = ptr_ok ? S_TBL_RD : S_OUT;
        else if (kind_r == K_MAP && pool_avail) st_nxt = S_FRAME_RD;
        else st_nxt = S_OUT;
      end
      S_FRAME_RD:   st_nxt = S_FRAME_WAIT;
      S_FRAME_WAIT: st_nxt = S_TBL_RD;
      S_OUT:        if (out_ready) st_nxt = S_IDLE;
      default:      st_nxt = S_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    tbl_we = 1'b0;
    tbl_addr = walk_addr;
    tbl_wd = 64'd0;
    pool_we = 1'b0;
    pool_waddr = PW'(fill_r);
    pool_wd = pa_r[12 +: FW];
    pool_raddr = PW'(alloc_r);
    unique case (st_r)
      S_CLEAR: begin
        tbl_we = 1'b1;
        tbl_addr = clr_r;
      end
      S_TBL_EVAL: begin
        if (lvl_r == 2'd3 && kind_r == K_MAP && !tbl_q_r[0]) begin
          tbl_we = 1'b1;
          tbl_wd = {12'd0, pa_r} | 64'd3;
        end else if (lvl_r == 2'd3 && kind_r == K_UNMAP && tbl_q_r[0]) begin
          tbl_we = 1'b1;
        end
      end
      // The pop already advanced the position; read the slot just taken.
      S_FRAME_RD: pool_raddr = PW'(alloc_r - CW'(1));
      S_FRAME_WAIT: begin
        tbl_we = 1'b1;
        tbl_wd = {{(52 - FW){1'b0}}, pool_q_r, 12'd3};
      end
      S_OUT: begin
        if (out_ready && kind_r == K_FREE && status_r == ST_OK) begin
          pool_we = 1'b1;
          pool_waddr = PW'(alloc_r - CW'(1));
        end else if (out_ready && kind_r == K_SEED && status_r == ST_OK) begin
          pool_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Datapath and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      clr_r <= '0;
      alloc_r <= '0;
      fill_r <= '0;
      kind_r <= K_TRANSLATE;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        S_CLEAR: clr_r <= clr_r + AW'(1);
        S_IDLE: begin
          if (in_valid) begin
            kind_r <= in_kind;
            va_r <= in_virtual_address;
            pa_r <= in_physical_address;
            cur_r <= FW'(in_root_frame);
            lvl_r <= 2'd0;
            res_r <= '0;
            status_r <= acc_status;
          end
        end
        S_POOL_RD: begin
          if (pool_avail) alloc_r <= alloc_r + CW'(1);
          else status_r <= ST_EMPTY;
        end
        S_POOL_WAIT: res_r <= {{(51 - FW){1'b0}}, pool_q_r, 12'd0};
        S_TBL_EVAL: begin
          if (lvl_r == 2'd3) begin
            if (kind_r == K_MAP) begin
              if (tbl_q_r[0]) status_r <= ST_ALREADY;
            end else if (!tbl_q_r[0]) begin
              status_r <= ST_L4_ABSENT;
            end else if (kind_r == K_TRANSLATE) begin
              res_r <= {tbl_q_r[62:12], 12'd0};
            end
          end else if (tbl_q_r[0]) begin
            if (ptr_ok) begin
              cur_r <= ptr_frame[FW-1:0];
              lvl_r <= lvl_r + 2'd1;
            end else begin
              status_r <= ST_BAD;
            end
          end else if (kind_r == K_MAP) begin
            if (pool_avail) alloc_r <= alloc_r + CW'(1);
            else status_r <= ST_EMPTY;
          end else begin
            status_r <= status_t'(4'(ST_L1_ABSENT) + {2'd0, lvl_r});
          end
        end
        S_FRAME_WAIT: begin
          cur_r <= pool_q_r;
          lvl_r <= lvl_r + 2'd1;
        end
        S_OUT: begin
          if (out_ready && status_r == ST_OK) begin
            if (kind_r == K_FREE) alloc_r <= alloc_r - CW'(1);
            if (kind_r == K_SEED) fill_r <= fill_r + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // pa_ok kept for a recheck against the registered address.
  `PT_ASSERT_IMP(a_pool_addr_ok, out_valid && status_r == ST_OK &&
                 (kind_r == K_FREE || kind_r == K_SEED), pa_ok,
                 "pool item passed with a bad frame address")
  `PT_ASSERT_IMP(a_alloc_bound, 1'b1, alloc_r <= fill_r, "alloc position beyond fill count")
  `PT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status),
                 "result dropped or changed while stalled")
  `PT_ASSERT_IMP(a_one_side, in_ready, !out_valid, "ready while a result is pending")
endmodule

[tb/tb_four_level_page_table_manager_top.sv]
// ----------------------------------------------------------------------------
// Page table engine regression
// Drives translate, map, unmap and pool items into the engine, predicts every
// status and address from a local copy of the tables and the frame pool, and
// compares each result in order under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_four_level_page_table_manager_top
  import fpt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFRAMES = NUM_FRAMES_DEF;
  localparam int NSLOTS  = POOL_SLOTS_DEF;
  localparam int RANDOM_ITEMS = 500;

  typedef struct {
    status_t     st;
    logic [62:0] addr;
  } walk_result_t;

  // Mirror of the engine: tables, frame pool and result queue.
  class page_walk_scoreboard;
    logic [63:0]  tables[int];
    logic [5:0]   frame_pool[NSLOTS];
    int           pop_pos;
    int           fill_cnt;
    walk_result_t pending_results[$];
    int           errors;

    function logic [63:0] entry(logic [63:0] frame, logic [8:0] idx);
      int k;
      k = int'(frame) * ENTRIES_PER_TABLE + idx;
      return tables.exists(k) ? tables[k] : 64'd0;
    endfunction

    function void set_entry(logic [63:0] frame, logic [8:0] idx, logic [63:0] val);
      tables[int'(frame) * ENTRIES_PER_TABLE + idx] = val;
    endfunction

    function bit pop_frame(output logic [63:0] frame);
      frame = 0;
      if (pop_pos >= fill_cnt || pop_pos >= NSLOTS) return 0;
      frame = frame_pool[pop_pos];
      pop_pos++;
      return 1;
    endfunction

    function status_t frame_addr_status(logic [51:0] pa);
      if (pa[11:0] != 0) return ST_BAD;
      if ((pa >> 12) >= NFRAMES) return ST_BAD;
      return ST_OK;
    endfunction

    // Walk the first three levels; allocate missing tables when building.
    function status_t walk(logic [5:0] root, logic [47:0] va, bit build,
                           output logic [63:0] leaf);
      logic [63:0] cur, nxt, e;
      logic [8:0] idx;
      leaf = 0;
      if (root == 0) return ST_NO_ROOT;
      if (root >= NFRAMES) return ST_BAD;
      cur = root;
      for (int lvl = 0; lvl < 3; lvl++) begin
        idx = level_index(va, lvl[1:0]);
        e = entry(cur, idx);
        if (!e[0]) begin
          if (!build) return status_t'(ST_L1_ABSENT + lvl);
          if (!pop_frame(nxt)) return ST_EMPTY;
          set_entry(cur, idx, (nxt << 12) | 64'd3);
        end else begin
          nxt = (e >> 12) & 64'hFF_FFFF_FFFF;
          if (nxt >= NFRAMES) return ST_BAD;
        end
        cur = nxt;
      end
      leaf = cur;
      return ST_OK;
    endfunction

    function void note_item(kind_t kind, logic [5:0] root, logic [47:0] va,
                            logic [51:0] pa);
      walk_result_t r;
      logic [63:0] leaf, e, fr;
      logic [8:0] idx;
      r.st = ST_OK;
      r.addr = 0;
      idx = level_index(va, 2'd3);
      case (kind)
        K_TRANSLATE, K_UNMAP: begin
          r.st = walk(root, va, 0, leaf);
          if (r.st == ST_OK) begin
            e = entry(leaf, idx);
            if (!e[0]) r.st = ST_L4_ABSENT;
            else if (kind == K_TRANSLATE) r.addr = e[62:0] & ~63'hFFF;
            else set_entry(leaf, idx, 64'd0);
          end
        end
        K_MAP: begin
          r.st = walk(root, va, 1, leaf);
          if (r.st == ST_OK) begin
            if (entry(leaf, idx) & 64'd1) r.st = ST_ALREADY;
            else set_entry(leaf, idx, {12'd0, pa} | 64'd3);
          end
        end
        K_ALLOC: begin
          if (pop_frame(fr)) r.addr = fr << 12;
          else r.st = ST_EMPTY;
        end
        K_FREE: begin
          r.st = frame_addr_status(pa);
          if (r.st == ST_OK) begin
            if (pop_pos == 0) r.st = ST_FULL;
            else begin
              pop_pos--;
              frame_pool[pop_pos] = pa[17:12];
            end
          end
        end
        K_SEED: begin
          r.st = frame_addr_status(pa);
          if (r.st == ST_OK) begin
            if (fill_cnt >= NSLOTS) r.st = ST_FULL;
            else begin
              frame_pool[fill_cnt] = pa[17:12];
              fill_cnt++;
            end
          end
        end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(logic [3:0] st, logic [62:0] addr);
      walk_result_t w;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result status=%0d addr=%h", st, addr));
        return;
      end
      w = pending_results.pop_front();
      if (st !== w.st)
        report($sformatf("status got %0d want %0d", st, w.st));
      if (addr !== w.addr)
        report($sformatf("address got %h want %h", addr, w.addr));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_kind = K_TRANSLATE;
  logic [5:0]  in_root_frame = '0;
  logic [47:0] in_virtual_address = '0;
  logic [51:0] in_physical_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_status;
  logic [62:0] out_result_address;

  page_walk_scoreboard walk_board = new();

  four_level_page_table_manager_top i_dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_kind, .in_root_frame,
    .in_virtual_address, .in_physical_address,
    .out_valid, .out_ready, .out_status, .out_result_address
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: check every accepted result, then pick the next ready level.
  // A tick counter picks a new stall mode at random: open, random, or mostly stalled.
  int unsigned stall_mode = 0;
  int unsigned stall_tick = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      walk_board.check_result(out_status, out_result_address);
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Present one item and hold it until the engine takes it. Valid stays high
  // on return so the next item of a burst follows without a bubble.
  task send_item(kind_t kind, logic [5:0] root, logic [47:0] va, logic [51:0] pa);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_root_frame <= root;
    in_virtual_address <= va;
    in_physical_address <= pa;
    do @(posedge clk); while (!in_ready);
    walk_board.note_item(kind, root, va, pa);
  endtask

  task idle_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task drain_results();
    in_valid <= 1'b0;
    while (walk_board.pending_results.size() != 0) @(posedge clk);
  endtask

  function logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Level indices from a few hot values so walks revisit the same tables.
  function logic [8:0] hot_index();
    case ($urandom_range(0, 4))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'h1FF;
      default: return 9'($urandom_range(0, 3));
    endcase
  endfunction

  function logic [47:0] pick_va();
    if ($urandom_range(0, 7) == 0) return 48'(rand64());
    return {hot_index(), hot_index(), hot_index(), hot_index(), 12'($urandom)};
  endfunction

  // Mostly small roots so page frames get reused as roots (aliased tables).
  function logic [5:0] pick_root();
    if ($urandom_range(0, 15) == 0) return 6'd0;
    if ($urandom_range(0, 3) == 0) return 6'($urandom_range(1, 63));
    return 6'($urandom_range(1, 12));
  endfunction

  function logic [51:0] pick_frame_pa();
    case ($urandom_range(0, 9))
      0: return 52'(rand64());
      1: return {34'($urandom_range(1, 1000)), 6'($urandom), 12'd0};
      2: return {40'($urandom_range(0, 63)), 12'($urandom_range(1, 4095))};
      default: return {40'($urandom_range(0, 12)), 12'd0};
    endcase
  endfunction

  task send_random_item();
    kind_t k;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) k = K_MAP;
    else if (sel < 50) k = K_TRANSLATE;
    else if (sel < 60) k = K_UNMAP;
    else if (sel < 70) k = K_ALLOC;
    else if (sel < 78) k = K_FREE;
    else if (sel < 96) k = K_SEED;
    else k = ($urandom_range(0, 1) != 0) ? K_NOP6 : K_NOP7;
    send_item(k, pick_root(), pick_va(), (k == K_FREE || k == K_SEED) ?
              pick_frame_pa() : 52'(rand64()));
  endtask

  initial begin
    logic [47:0] va_top;
    int burst;
    int sent;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: no root, empty tables and pool, bad addresses, a partial map.
    va_top = 48'hFFFF_FFFF_FFFF;
    send_item(K_TRANSLATE, 6'd0, va_top, '0);
    send_item(K_MAP, 6'd0, va_top, '1);
    send_item(K_UNMAP, 6'd0, '0, '0);
    send_item(K_TRANSLATE, 6'd63, '0, '0);
    send_item(K_ALLOC, 6'd1, '0, '0);
    send_item(K_FREE, 6'd1, '0, 52'h5000);
    send_item(K_SEED, 6'd1, '0, 52'h1001);
    send_item(K_SEED, 6'd1, '0, 52'h40000);
    send_item(K_SEED, 6'd1, '0, '1);
    send_item(K_SEED, 6'd1, '0, 52'h2000);
    send_item(K_SEED, 6'd1, '0, 52'h3000);
    send_item(K_SEED, 6'd1, '0, 52'h4000);
    send_item(K_MAP, 6'd1, va_top, '1);
    send_item(K_MAP, 6'd1, va_top, 52'h12345);
    send_item(K_TRANSLATE, 6'd1, va_top, '0);
    send_item(K_TRANSLATE, 6'd1, 48'h0000_0000_1000, '0);
    send_item(K_SEED, 6'd1, '0, 52'h5000);
    send_item(K_MAP, 6'd1, 48'h0000_0000_0000, 52'h7000);
    send_item(K_TRANSLATE, 6'd1, 48'h0000_0000_0000, '0);
    // Level-4 table used as a root: its page entry points past the frames.
    send_item(K_TRANSLATE, 6'd4, va_top, '0);
    send_item(K_UNMAP, 6'd1, va_top, '0);
    send_item(K_UNMAP, 6'd1, va_top, '0);
    send_item(K_NOP6, 6'd63, va_top, '1);
    send_item(K_NOP7, 6'd0, '0, '0);
    send_item(K_FREE, 6'd1, '0, 52'h3F000);

    // Random traffic in bursts; halfway, hold off until the engine drains.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst; i++) begin
        send_random_item();
        sent++;
      end
      if (sent >= RANDOM_ITEMS / 2 && sent - burst < RANDOM_ITEMS / 2)
        drain_results();
      else if ($urandom_range(0, 3) != 0)
        idle_sender($urandom_range(1, 20));
    end

    drain_results();
    repeat (30) @(posedge clk);
    if (walk_board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Timeout covering the clearing pass plus the traffic, several times over.
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[four_level_page_table_manager_top.f]
+incdir+hdl
hdl/fpt_pkg.sv
hdl/four_level_page_table_manager_top.sv
tb/tb_four_level_page_table_manager_top.sv
